// ===== hdl/per_cpu_page_free_list_allocator_core_macros.svh =====
// assertion macros for the per-cpu page allocator
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define PCPA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcpa assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define PCPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcpa assertion failed");
`else
`define PCPA_ASSERT_SAME(lbl, ante, cons)
`define PCPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/pcpa_pkg.sv =====
// shared types and constants of the per-cpu page allocator
package pcpa_pkg;

    localparam int DEF_NUM_CPUS  = 8;
    localparam int DEF_MAX_PAGES = 32768;
    localparam int DEF_SLOT_W    = $clog2(DEF_MAX_PAGES + 1);
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_NUM_W    = 32 - PAGE_SHIFT;
    localparam int PAGE_MASK     = (1 << PAGE_SHIFT) - 1;
    localparam int STEAL_LIMIT   = 64;
    localparam int STEAL_CNT_W   = $clog2(STEAL_LIMIT + 1);

    typedef enum logic [1:0] {
        STAT_ALLOC    = 2'd0,
        STAT_FREED    = 2'd1,
        STAT_NO_PAGE  = 2'd2,
        STAT_BAD_ADDR = 2'd3
    } status_t;

    typedef enum logic {
        ACT_FREE  = 1'b0,
        ACT_ALLOC = 1'b1
    } act_t;

    typedef enum logic {
        REG_POOL_START = 1'b0,
        REG_POOL_STOP  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MOVE,
        S_POP,
        S_RESP
    } state_t;

endpackage

// ===== hdl/pcpa_link_ram.sv =====
// link memory: one next pointer per page, registered read
module pcpa_link_ram #(
    parameter int DEPTH = pcpa_pkg::DEF_MAX_PAGES,
    parameter int DW    = pcpa_pkg::DEF_SLOT_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/per_cpu_page_free_list_allocator_core.sv =====
// top level of the per-cpu page allocator with free-list stealing
//
//  channel   dir  transaction contents
//  -------   ---  ---------------------------------------------------------
//  apb       in   pool_start (paddr 0), pool_stop (paddr 4), read back
//  s_axis    in   tuser: action; tdata: cpu_id, page_address
//  m_axis    out  tuser: status; tdata: granted_address
//
//  free: address check and push in S_EXEC, then the result in S_RESP
//  alloc with a non-empty list: head read and link read in S_EXEC, pop in S_POP
//  alloc with an empty list: S_SCAN steps past each other cpu index, each
//    stolen page takes a link read in S_SCAN and a link write in S_MOVE,
//    and a final pop in S_POP when a page is found
//  one item in flight; the next is taken while a result still waits on m_axis
//  reset: all lists empty at once, link memory needs no clearing
module per_cpu_page_free_list_allocator_core #(
    parameter int NUM_CPUS  = pcpa_pkg::DEF_NUM_CPUS,
    parameter int MAX_PAGES = pcpa_pkg::DEF_MAX_PAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] cpu_id, [34:3] page_address, [39:35] zero
    input  logic [0:0]  s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] granted_address
    output logic [1:0]  m_tuser    // [1:0] status
);

    import pcpa_pkg::*;

    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int VW = $clog2(NUM_CPUS + 1);
    localparam int IW = $clog2(MAX_PAGES);
    localparam int SW = $clog2(MAX_PAGES + 1);
    localparam int BW = PAGE_NUM_W + 1;

    // reduce the requesting cpu index into range, at most eight subtract steps
    function automatic logic [CW-1:0] cpu_mod(input logic [2:0] id);
        int r;
        r = int'(id);
        for (int k = 0; k < 8; k++)
        begin
            if (r >= NUM_CPUS)
            begin
                r = r - NUM_CPUS;
            end
        end
        return CW'(r);
    endfunction

    // configuration registers
    logic [31:0] pool_start_reg;
    logic [31:0] pool_stop_reg;
    logic [BW-1:0] base_page_reg;   // first whole page at or above pool_start

    // list heads, slot = page index + 1, zero is empty
    logic [SW-1:0] heads_reg  [NUM_CPUS];
    logic [SW-1:0] heads_next [NUM_CPUS];

    state_t        state_reg, state_next;
    act_t          act_reg, act_next;
    logic [CW-1:0] cpu_reg, cpu_next;
    logic [31:0]   addr_reg, addr_next;
    logic [SW-1:0] own_head_reg, own_head_next;   // copy of the requester's head
    logic [SW-1:0] slot_reg, slot_next;           // page being popped or moved
    logic [VW-1:0] vic_reg, vic_next;             // victim cpu of the steal scan
    logic [STEAL_CNT_W-1:0] left_reg, left_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    // link memory port
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [SW-1:0] link_wdata;
    logic          link_re;
    logic [IW-1:0] link_raddr;
    logic [SW-1:0] link_rdata;

    // single read port on the head registers
    logic [CW-1:0] head_raddr;
    logic [SW-1:0] head_rd;

    // free address check
    logic [32:0]   start_round;
    logic [BW-1:0] page_diff;
    logic          free_ok;
    logic [BW-1:0] grant_page;
    logic          out_free;
    logic          cfg_wr;

    pcpa_link_ram #(
        .DEPTH (MAX_PAGES),
        .DW    (SW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg <= '0;
            pool_stop_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_POOL_START: pool_start_reg <= pwdata;
                REG_POOL_STOP:  pool_stop_reg  <= pwdata;
                default:        pool_stop_reg  <= pool_stop_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_POOL_START: prdata = pool_start_reg;
            REG_POOL_STOP:  prdata = pool_stop_reg;
            default:        prdata = '0;
        endcase
    end

    // base page rounded up, registered, so it lags a write of pool_start_reg
    assign start_round = {1'b0, pool_start_reg} + 33'(PAGE_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg <= '0;
        end
        else
        begin
            base_page_reg <= start_round[32:PAGE_SHIFT];
        end
    end

    // ---------------- datapath helpers ----------------
    assign head_raddr = (state_reg == S_SCAN) ? vic_reg[CW-1:0] : cpu_reg;
    assign head_rd    = heads_reg[head_raddr];

    // an aligned address at or above pool_start never lies below the base page
    assign page_diff = {1'b0, addr_reg[31:PAGE_SHIFT]} - base_page_reg;
    assign free_ok   = (addr_reg[PAGE_SHIFT-1:0] == '0)
                    && (addr_reg >= pool_start_reg)
                    && (addr_reg < pool_stop_reg)
                    && (page_diff < BW'(MAX_PAGES));

    assign grant_page = base_page_reg + BW'(IW'(slot_reg - SW'(1)));

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        cpu_next        = cpu_reg;
        addr_next       = addr_reg;
        own_head_next   = own_head_reg;
        slot_next       = slot_reg;
        vic_next        = vic_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        heads_next      = heads_reg;
        link_we         = 1'b0;
        link_waddr      = '0;
        link_wdata      = '0;
        link_re         = 1'b0;
        link_raddr      = '0;
        // result taken downstream frees the output register
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = act_t'(s_tuser[0]);
                    cpu_next   = cpu_mod(s_tdata[2:0]);
                    addr_next  = s_tdata[34:3];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                own_head_next = head_rd;
                res_addr_next = '0;
                if (act_reg == ACT_FREE)
                begin
                    if (free_ok)
                    begin
                        // push: new page links to the old head
                        link_we             = 1'b1;
                        link_waddr          = page_diff[IW-1:0];
                        link_wdata          = head_rd;
                        heads_next[cpu_reg] = SW'(page_diff) + SW'(1);
                        res_status_next     = STAT_FREED;
                    end
                    else
                    begin
                        res_status_next = STAT_BAD_ADDR;
                    end
                    state_next = S_RESP;
                end
                else if (head_rd != '0)
                begin
                    link_re    = 1'b1;
                    link_raddr = IW'(head_rd - SW'(1));
                    slot_next  = head_rd;
                    state_next = S_POP;
                end
                else
                begin
                    // own list empty: scan the others in ascending order
                    vic_next   = '0;
                    left_next  = STEAL_CNT_W'(STEAL_LIMIT);
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if ((vic_reg == VW'(NUM_CPUS)) || (left_reg == '0))
                begin
                    if (own_head_reg == '0)
                    begin
                        res_status_next = STAT_NO_PAGE;
                        res_addr_next   = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        link_re    = 1'b1;
                        link_raddr = IW'(own_head_reg - SW'(1));
                        slot_next  = own_head_reg;
                        state_next = S_POP;
                    end
                end
                else if ((vic_reg[CW-1:0] == cpu_reg) || (head_rd == '0))
                begin
                    vic_next = vic_reg + VW'(1);
                end
                else
                begin
                    link_re    = 1'b1;
                    link_raddr = IW'(head_rd - SW'(1));
                    slot_next  = head_rd;
                    state_next = S_MOVE;
                end
            end

            S_MOVE:
            begin
                // victim head takes the link, the page goes on top of our list
                link_we                      = 1'b1;
                link_waddr                   = IW'(slot_reg - SW'(1));
                link_wdata                   = own_head_reg;
                heads_next[vic_reg[CW-1:0]]  = link_rdata;
                heads_next[cpu_reg]          = slot_reg;
                own_head_next                = slot_reg;
                left_next                    = left_reg - STEAL_CNT_W'(1);
                state_next                   = S_SCAN;
            end

            S_POP:
            begin
                heads_next[cpu_reg] = link_rdata;
                res_addr_next       = {grant_page[PAGE_NUM_W-1:0], PAGE_SHIFT'(0)};
                res_status_next     = STAT_ALLOC;
                state_next          = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_addr_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            heads_reg    <= heads_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        cpu_reg        <= cpu_next;
        addr_reg       <= addr_next;
        own_head_reg   <= own_head_next;
        slot_reg       <= slot_next;
        vic_reg        <= vic_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
`include "per_cpu_page_free_list_allocator_core_macros.svh"

    // an accepted transaction goes straight to its first working state
    `PCPA_ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, state_reg == S_EXEC)
    // a page is moved only while the steal budget lasts and from a real slot
    `PCPA_ASSERT_SAME(a_move_budget, state_reg == S_MOVE, (left_reg != '0) && (slot_reg != '0))
    // only a grant carries an address
    `PCPA_ASSERT_SAME(a_zero_addr, m_tvalid && (m_tuser != STAT_ALLOC), m_tdata == '0)

endmodule
